@@ hdl/mvtf_pkg.sv @@
package mvtf_pkg;

  localparam int NUM_CHANNELS_DEF = 16;

  // Request codes.
  localparam logic [1:0] REQ_PASS    = 2'd0;
  localparam logic [1:0] REQ_REFRESH = 2'd1;
  localparam logic [1:0] REQ_ALL_OFF = 2'd2;

  // Event kinds.
  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_CTRL = 2'd1;

  // Controller numbers and fixed channel.
  localparam logic [6:0] CTL_MAIN_VOLUME    = 7'd7;
  localparam logic [6:0] CTL_ALL_SOUNDS_OFF = 7'd120;
  localparam logic [6:0] CTL_ALL_NOTES_OFF  = 7'd123;
  localparam logic [3:0] DRUM_CHANNEL       = 4'd9;

  localparam logic [6:0] MAX_DATA     = 7'd127;
  localparam logic [6:0] VOLUME_RESET = 7'd100;
  localparam logic [8:0] FACTOR_RESET = 9'd100;

  // floor(p / 100) = (p * 83887) >> 23 for every p below 91180.
  localparam logic [16:0] RECIP_100   = 17'd83887;
  localparam int          RECIP_SHIFT = 23;

  // Register map: one bit of word index.
  localparam logic REG_VOLUME_FACTOR = 1'b0;
  localparam logic REG_PITCH_SHIFT   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;    // take raw * factor into the product register
    logic finish;  // divide the product by 100 and clamp
  } scale_ctl_t;

endpackage

@@ hdl/mvtf_scale.sv @@
module mvtf_scale (
  input  logic               clk,
  input  mvtf_pkg::scale_ctl_t ctl,
  input  logic [6:0]         raw,
  input  logic [8:0]         factor,
  output logic [6:0]         scaled
);
  import mvtf_pkg::*;

  logic [15:0] prod;
  logic [32:0] quot_full;
  logic [9:0]  quot;

  // Second stage: reciprocal multiply stands in for the division by 100.
  assign quot_full = 33'(prod) * 33'(RECIP_100);
  assign quot      = quot_full[RECIP_SHIFT +: 10];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= 16'(raw) * 16'(factor);
    end
    if (ctl.finish) begin
      scaled <= (quot > 10'(MAX_DATA)) ? MAX_DATA : quot[6:0];
    end
  end

endmodule

@@ hdl/midi_volume_transpose_filter.sv @@
// A key or other event goes from acceptance through the emit state to the output
// register; a main volume controller goes through the two multiply stages first.
// Requests are taken only while idle. A refresh emits one word per channel (memory
// read, two multiply stages, emit); an all-off request emits one word per cycle
// while the output does not stall. Reset (rst, synchronous): idle,
// no word pending, factor 100, pitch shift 0, every channel volume reads as 100.
module midi_volume_transpose_filter #(
  parameter int NUM_CHANNELS = mvtf_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [1:0]  event_kind,
  input  logic [3:0]  channel,
  input  logic [6:0]  key_or_param,
  input  logic [6:0]  data_value,
  // Output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_channel,
  output logic [6:0]  out_key_or_param,
  output logic [6:0]  out_value,
  output logic        last
);
  import mvtf_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. Only bit 2 of the address selects a register;
  // the low address bits are ignored as on a word-aligned bus.
  // ---------------------------------------------------------------------------
  logic [8:0] volume_factor;
  logic [7:0] pitch_shift;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_factor <= FACTOR_RESET;
      pitch_shift   <= 8'd0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_VOLUME_FACTOR: volume_factor <= pwdata[8:0];
        REG_PITCH_SHIFT:   pitch_shift   <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_VOLUME_FACTOR: prdata = 32'(volume_factor);
      REG_PITCH_SHIFT:   prdata = 32'(pitch_shift);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control state and the latched request.
  // ---------------------------------------------------------------------------
  state_t state, state_next;

  logic [1:0]      req_r;
  logic [1:0]      kind_r;
  logic [3:0]      chan_r;
  logic [6:0]      kp_r;
  logic [6:0]      val_r;
  logic            vol_r;
  logic [CH_W-1:0] cnt;        // channel being swept by refresh or all-off
  logic            sub;        // all-off: 0 for notes off, 1 for sounds off

  logic in_fire;
  logic emit_fire;
  logic sweep_end;
  logic word_last;
  logic vol_in;

  assign in_fire   = in_valid && in_ready;
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);
  assign sweep_end = (cnt == CH_W'(NUM_CHANNELS - 1));
  assign vol_in    = (event_kind == KIND_CTRL) && (key_or_param == CTL_MAIN_VOLUME);

  // The last word of a request: every pass word, the final channel of a
  // refresh, and the sounds-off word of the final channel of an all-off.
  always_comb begin
    priority case (req_r)
      REQ_REFRESH: word_last = sweep_end;
      REQ_ALL_OFF: word_last = sweep_end && sub;
      default:     word_last = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Channel volume store: a synchronous memory with a registered read.
  // Valid bits stand in for the reset value of 100; an entry never written
  // reads as 100. Writes happen only at acceptance, reads only during a
  // refresh sweep, so the two never meet on the same entry.
  // ---------------------------------------------------------------------------
  logic [6:0]            vol_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vol_valid;
  logic [6:0]            rd_data;
  logic                  rd_valid;
  logic                  mem_we;

  assign mem_we = in_fire && (req_type == REQ_PASS) && vol_in &&
                  ({1'b0, channel} < 5'(NUM_CHANNELS));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vol_mem[channel[CH_W-1:0]] <= data_value;
    end
    if (state == ST_READ) begin
      rd_data  <= vol_mem[cnt];
      rd_valid <= vol_valid[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_valid <= '0;
    end else if (mem_we) begin
      vol_valid[channel[CH_W-1:0]] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Volume scaling: two registered stages, product then divide and clamp.
  // ---------------------------------------------------------------------------
  scale_ctl_t scale_ctl;
  logic [6:0] scale_raw;
  logic [6:0] scaled;

  assign scale_raw = (req_r == REQ_REFRESH) ? (rd_valid ? rd_data : VOLUME_RESET) : val_r;

  mvtf_scale u_scale (
    .clk    (clk),
    .ctl    (scale_ctl),
    .raw    (scale_raw),
    .factor (volume_factor),
    .scaled (scaled)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          priority case (req_type)
            REQ_PASS:    state_next = vol_in ? ST_MUL1 : ST_EMIT;
            REQ_REFRESH: state_next = ST_READ;
            REQ_ALL_OFF: state_next = ST_EMIT;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire) begin
          if (word_last) begin
            state_next = ST_IDLE;
          end else if (req_r == REQ_REFRESH) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready         = 1'b0;
    scale_ctl.load   = 1'b0;
    scale_ctl.finish = 1'b0;
    unique case (state)
      ST_IDLE: in_ready         = 1'b1;
      ST_MUL1: scale_ctl.load   = 1'b1;
      ST_MUL2: scale_ctl.finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      sub   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        cnt <= '0;
        sub <= 1'b0;
      end else if (emit_fire && !word_last) begin
        if (req_r == REQ_ALL_OFF && !sub) begin
          sub <= 1'b1;
        end else begin
          sub <= 1'b0;
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r  <= req_type;
      kind_r <= event_kind;
      chan_r <= channel;
      kp_r   <= key_or_param;
      val_r  <= data_value;
      vol_r  <= vol_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Result word assembly. Key events off the drum channel are transposed and
  // the key is held to 0..127.
  // ---------------------------------------------------------------------------
  logic signed [8:0] key_sum;
  logic [6:0]        key_sat;
  logic [1:0]        word_kind;
  logic [3:0]        word_chan;
  logic [6:0]        word_kp;
  logic [6:0]        word_val;

  assign key_sum = $signed({2'b00, kp_r}) + $signed({pitch_shift[7], pitch_shift});

  always_comb begin
    if (key_sum < 0) begin
      key_sat = 7'd0;
    end else if (key_sum > $signed({2'b00, MAX_DATA})) begin
      key_sat = MAX_DATA;
    end else begin
      key_sat = key_sum[6:0];
    end
  end

  always_comb begin
    priority case (req_r)
      REQ_REFRESH: begin
        word_kind = KIND_CTRL;
        word_chan = 4'(cnt);
        word_kp   = CTL_MAIN_VOLUME;
        word_val  = scaled;
      end
      REQ_ALL_OFF: begin
        word_kind = KIND_CTRL;
        word_chan = 4'(cnt);
        word_kp   = sub ? CTL_ALL_SOUNDS_OFF : CTL_ALL_NOTES_OFF;
        word_val  = 7'd0;
      end
      default: begin
        word_kind = kind_r;
        word_chan = chan_r;
        word_kp   = ((kind_r == KIND_KEY) && (chan_r != DRUM_CHANNEL)) ? key_sat : kp_r;
        word_val  = vol_r ? scaled : val_r;
      end
    endcase
  end

  // Output register: holds a word until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_kind         <= word_kind;
      out_channel      <= word_chan;
      out_key_or_param <= word_kp;
      out_value        <= word_val;
      last             <= word_last;
    end
  end

endmodule
